// ===== src/bm25_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_pkg
// Shared constants and types of the BM25 term weight core.
// ----------------------------------------------------------------------------
package bm25_pkg;

  // Divider geometry: quotient/dividend bits and divisor bits.
  localparam int DIV_QW = 58;
  localparam int DIV_DW = 52;

  // Log2 fraction bits and ln(2) as Q0.32.
  localparam int          LOG_FRAC = 24;
  localparam logic [31:0] LN2_Q32  = 32'd2977044472;

  // Configuration register indexes.
  localparam logic [7:0] CFG_TOTAL_DOCS = 8'd0;
  localparam logic [7:0] CFG_AVG_LEN    = 8'd1;
  localparam logic [7:0] CFG_K1         = 8'd2;
  localparam logic [7:0] CFG_B          = 8'd3;

  // Per-request data that rides along the pipeline.
  typedef struct packed {
    logic [15:0] tf;
    logic [9:0]  k;
    logic [8:0]  b;
    logic        bad;
    logic        idf_zero;
    logic [47:0] lq;
    logic [21:0] idf;
  } side_t;

endpackage

// ===== src/bm25_term_weight_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_term_weight_core
// Okapi BM25 term weight per posting, unsigned Q16.16 result.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one posting per request: term frequency, document
//   length and document frequency. The out_ stream returns one weight per
//   posting, in order, with tuser set when the average length is zero.
//   The cfg_ channel writes N, average length, k1 and b; it is always ready.
//   The user writes it only while no posting is in flight; it is not enforced.
// Timing:
//   A new posting is accepted every cycle unless the output stalls. A posting
//   passes through the two 58-stage restoring dividers (idf ratio with
//   length ratio side by side, then the term frequency quotient) and the
//   27-stage log2 squaring pipeline.
// Reset:
//   Valid bits clear, k1 returns to 307, b to 192, N and average length to 0.
// Stall:
//   While a result waits and out_tready is low the whole pipeline holds and
//   in_tready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bm25_term_weight_core import bm25_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // term_freq[15:0], doc_len[39:16], doc_freq[63:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // weight_q16[31:0]
  output logic        out_tuser,  // bad_average[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [23:0] total_docs_r;
  logic [31:0] avg_len_r;
  logic [9:0]  k1_r;
  logic [8:0]  b_r;

  logic        en;
  logic [15:0] tf;
  logic [23:0] len;
  logic [23:0] df;

  logic [25:0] idf_num;
  logic [24:0] idf_den;
  logic [8:0]  b_eff;
  logic [32:0] b_len;
  side_t       side0_nxt;

  logic              vld0_r;
  side_t             side0_r;
  logic [DIV_QW-1:0] num1_r, num2_r;
  logic [DIV_DW-1:0] den1_r, den2_r;
  logic [DIV_QW-1:0] quo1, quo2, quo3;

  logic  dly1_vld;
  side_t dly1_side;
  side_t log_in_side;
  logic  log_vld;
  side_t log_side;

  logic        vld1_r, vld2_r, vld3_r, vld4_r;
  side_t       side1_r, side2_r, side3_r, side4_r;
  logic [48:0] l_r;
  logic [34:0] plo_r;
  logic [33:0] phi_r;
  logic [58:0] kl_r;
  logic [26:0] tk_r;
  logic [DIV_QW-1:0] num3_r;
  logic [DIV_DW-1:0] den3_r;

  logic  dly2_vld;
  side_t dly2_side;
  logic  vld5_r;
  side_t side5_r;
  logic [40:0] prod_r;
  logic [18:0] tfn;
  logic [41:0] w_sum;

  logic        out_vld_r;
  logic [31:0] out_data_r;
  logic        out_user_r;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_docs_r <= '0;
      avg_len_r    <= '0;
      k1_r         <= 10'd307;
      b_r          <= 9'd192;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOTAL_DOCS: total_docs_r <= cfg_data[23:0];
        CFG_AVG_LEN:    avg_len_r    <= cfg_data;
        CFG_K1:         k1_r         <= cfg_data[9:0];
        CFG_B:          b_r          <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  assign tf  = in_tdata[15:0];
  assign len = in_tdata[39:16];
  assign df  = in_tdata[63:40];

  // Front stage: ratio operands and flags.
  always_comb begin
    idf_num = {1'b0, total_docs_r, 1'b0} + 26'd2;
    idf_den = {df, 1'b1};
    b_eff   = (b_r > 9'd256) ? 9'd256 : b_r;
    b_len   = b_eff * len;
    side0_nxt          = '0;
    side0_nxt.tf       = tf;
    side0_nxt.k        = k1_r;
    side0_nxt.b        = b_eff;
    side0_nxt.bad      = (avg_len_r == 32'd0);
    side0_nxt.idf_zero = (df == 24'd0) || (idf_num <= {1'b0, idf_den});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0_r <= side0_nxt;
      num1_r  <= {idf_num, 32'd0};
      den1_r  <= {27'd0, idf_den};
      num2_r  <= {9'd0, b_len, 16'd0};
      den2_r  <= {20'd0, avg_len_r};
    end
  end

  // Idf ratio and length ratio run side by side.
  bm25_div u_div_idf (
    .clk (clk), .en (en), .in_num (num1_r), .in_den (den1_r), .out_quo (quo1)
  );

  bm25_div u_div_len (
    .clk (clk), .en (en), .in_num (num2_r), .in_den (den2_r), .out_quo (quo2)
  );

  bm25_dly u_dly_front (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld (vld0_r), .in_side (side0_r),
    .out_vld (dly1_vld), .out_side (dly1_side)
  );

  always_comb begin
    log_in_side    = dly1_side;
    log_in_side.lq = quo2[47:0];
  end

  bm25_log u_log (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld (dly1_vld), .in_q (quo1), .in_side (log_in_side),
    .out_vld (log_vld), .out_side (log_side)
  );

  // Length factor, k1 product in two halves, then the numerator and denominator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= log_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= log_side;
      l_r     <= {32'd0, (9'd256 - log_side.b), 8'd0} + {1'b0, log_side.lq};
      side2_r <= side1_r;
      plo_r   <= side1_r.k * l_r[24:0];
      phi_r   <= side1_r.k * l_r[48:25];
      side3_r <= side2_r;
      kl_r    <= {phi_r, 25'd0} + {24'd0, plo_r};
      tk_r    <= side2_r.tf * ({1'b0, side2_r.k} + 11'd256);
      side4_r <= side3_r;
      num3_r  <= {7'd0, tk_r, 24'd0};
      den3_r  <= {20'd0, side3_r.tf, 16'd0} + {1'b0, kl_r[58:8]};
    end
  end

  bm25_div u_div_tfn (
    .clk (clk), .en (en), .in_num (num3_r), .in_den (den3_r), .out_quo (quo3)
  );

  bm25_dly u_dly_back (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld (vld4_r), .in_side (side4_r),
    .out_vld (dly2_vld), .out_side (dly2_side)
  );

  // Zero term frequency gives a zero normalized frequency.
  assign tfn = (dly2_side.tf == 16'd0) ? 19'd0 : quo3[18:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (en) begin
      vld5_r <= dly2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r <= dly2_side;
      prod_r  <= dly2_side.idf * tfn;
    end
  end

  // Round to Q16.16; the product stays well below the saturation point,
  // but the clamp compares the 26-bit result with its own maximum and never fires.
  assign w_sum = {1'b0, prod_r} + 42'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_user_r <= side5_r.bad;
      if (side5_r.bad) begin
        out_data_r <= '0;
      end else if (w_sum[41:16] > 26'h3FFFFFF) begin
        out_data_r <= 32'hFFFF_FFFF;
      end else begin
        out_data_r <= {6'd0, w_sum[41:16]};
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== src/bm25_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bm25_div import bm25_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_QW-1:0] in_num,
  input  logic [DIV_DW-1:0] in_den,
  output logic [DIV_QW-1:0] out_quo
);

  logic [DIV_DW-1:0] rem_r [DIV_QW-1];
  logic [DIV_DW-1:0] den_r [DIV_QW-1];
  logic [DIV_QW-1:0] num_r [DIV_QW];

  for (genvar s = 0; s < DIV_QW; s++) begin : g_stage
    logic [DIV_DW-1:0] src_rem;
    logic [DIV_DW-1:0] src_den;
    logic [DIV_QW-1:0] src_num;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;
    logic [DIV_DW-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign src_rem = '0;
      assign src_den = in_den;
      assign src_num = in_num;
    end else begin : g_next
      assign src_rem = rem_r[s-1];
      assign src_den = den_r[s-1];
      assign src_num = num_r[s-1];
    end

    // Shift in the next dividend bit and subtract when it fits.
    assign trial   = {src_rem, src_num[DIV_QW-1]};
    assign diff    = trial - {1'b0, src_den};
    assign ge      = trial >= {1'b0, src_den};
    assign rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s] <= {src_num[DIV_QW-2:0], ge};
      end
    end

    if (s < DIV_QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          den_r[s] <= src_den;
        end
      end
    end
  end

  assign out_quo = num_r[DIV_QW-1];

endmodule

// ===== src/bm25_dly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_dly
// Valid and side data delay line matching the divider latency.
// ----------------------------------------------------------------------------
module bm25_dly import bm25_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  side_t in_side,
  output logic  out_vld,
  output side_t out_side
);

  logic [DIV_QW-1:0] vld_r;
  side_t             side_r [DIV_QW];

  // Valid bits are control state and get cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_QW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 1; i < DIV_QW; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_vld  = vld_r[DIV_QW-1];
  assign out_side = side_r[DIV_QW-1];

endmodule

// ===== src/bm25_log.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_log
// Pipelined log2 by repeated squaring, scaled by ln(2) into the idf.
// ----------------------------------------------------------------------------
module bm25_log import bm25_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DIV_QW-1:0] in_q,
  input  side_t             in_side,
  output logic              out_vld,
  output side_t             out_side
);

  logic [4:0]          ip0_r;
  logic [31:0]         m0_r;
  side_t               side0_r;
  logic [4:0]          ip_nxt;
  logic [31:0]         m_nxt0;

  logic [31:0]         m_r    [LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_r [LOG_FRAC];
  logic [4:0]          ip_r   [LOG_FRAC];
  side_t               side_r [LOG_FRAC];
  logic [31:0]         m_in   [LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_in[LOG_FRAC];
  logic [4:0]          ip_in  [LOG_FRAC];
  side_t               side_in[LOG_FRAC];
  logic [31:0]         m_nxt  [LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_nxt[LOG_FRAC];

  logic [60:0]         prod_r;
  side_t               sidep_r;
  logic [60:0]         prod_nxt;
  logic [61:0]         idf_sum;
  side_t               side_fin;
  side_t               side_out_r;

  logic [LOG_FRAC+2:0] vld_r;

  // Leading one gives the integer part; the mantissa is normalized to Q1.31.
  always_comb begin
    ip_nxt = '0;
    for (int i = 33; i < DIV_QW; i++) begin
      if (in_q[i]) begin
        ip_nxt = 5'(i - 32);
      end
    end
    m_nxt0 = 32'(in_q >> ({1'b0, ip_nxt} + 6'd1));
  end

  // Each squaring stage yields one fraction bit.
  always_comb begin
    m_in[0]    = m0_r;
    frac_in[0] = '0;
    ip_in[0]   = ip0_r;
    side_in[0] = side0_r;
    for (int s = 1; s < LOG_FRAC; s++) begin
      m_in[s]    = m_r[s-1];
      frac_in[s] = frac_r[s-1];
      ip_in[s]   = ip_r[s-1];
      side_in[s] = side_r[s-1];
    end
    for (int s = 0; s < LOG_FRAC; s++) begin
      logic [63:0] sq;
      sq = m_in[s] * m_in[s];
      frac_nxt[s] = frac_in[s];
      if (sq[63]) begin
        m_nxt[s] = sq[63:32];
        frac_nxt[s][LOG_FRAC-1-s] = 1'b1;
      end else begin
        m_nxt[s] = sq[62:31];
      end
    end
  end

  // Scale log2 by ln(2) and round to Q16.
  assign prod_nxt = {ip_r[LOG_FRAC-1], frac_r[LOG_FRAC-1]} * LN2_Q32;
  assign idf_sum  = {1'b0, prod_r} + (62'd1 << 39);

  // The idf is zero when df is zero or the log argument is not above one.
  always_comb begin
    side_fin     = sidep_r;
    side_fin.idf = sidep_r.idf_zero ? 22'd0 : idf_sum[61:40];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LOG_FRAC+1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip0_r   <= ip_nxt;
      m0_r    <= m_nxt0;
      side0_r <= in_side;
      for (int s = 0; s < LOG_FRAC; s++) begin
        m_r[s]    <= m_nxt[s];
        frac_r[s] <= frac_nxt[s];
        ip_r[s]   <= ip_in[s];
        side_r[s] <= side_in[s];
      end
      prod_r     <= prod_nxt;
      sidep_r    <= side_r[LOG_FRAC-1];
      side_out_r <= side_fin;
    end
  end

  assign out_vld  = vld_r[LOG_FRAC+2];
  assign out_side = side_out_r;

endmodule

// ===== tb/bm25_term_weight_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_term_weight_core_tb
// Self-checking testbench of the BM25 term weight core.
// ----------------------------------------------------------------------------
// Postings are streamed into the core under several register settings. First
// come postings after reset, a directed table and extreme registers, then
// random postings. Each returned weight is checked against a typed-in value
// or an integer BM25 computation kept in this bench. Sender and receiver
// idle at random; a long receiver hold-off fills the pipeline, stalling input.
// ----------------------------------------------------------------------------
module bm25_term_weight_core_tb import bm25_pkg::*;;

  localparam int LATENCY   = 150;
  localparam int MAX_CYCLE = 1500000;

  // One directed row: the posting, plus an optional typed-in weight.
  typedef struct {
    logic [15:0] tf;
    logic [23:0] len;
    logic [23:0] df;
    bit          known;
    logic [31:0] weight;
    logic        bad;
  } posting_row_t;

  typedef struct packed {
    logic [31:0] weight;
    logic        bad;
  } weight_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Register copies kept by the predictor.
  logic [23:0] n_docs;
  logic [31:0] avg_len;
  logic [9:0]  k1;
  logic [8:0]  b_norm;

  weight_t     weight_queue[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold_recv = 1'b0;
  int          hold_cycles = 0;

  bm25_term_weight_core i_dut (.*);

  always #2 clk = ~clk;

  // log2 of a Q32.32 value at least one, with 24 fraction bits.
  function automatic logic [63:0] log2_frac24(logic [63:0] q);
    int          p;
    logic [63:0] m;
    logic [63:0] res;
    logic [127:0] sq;
    p = 63;
    while (p > 32 && q[p] == 1'b0) p--;
    res = 64'(p - 32) << 24;
    m = q >> (p - 31);
    for (int i = 23; i >= 0; i--) begin
      sq = 128'(m) * 128'(m);
      m = 64'(sq >> 31);
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  // Expected BM25 weight of one posting under the current registers.
  function automatic weight_t bm25_weight(logic [15:0] tf, logic [23:0] len,
                                          logic [23:0] df);
    weight_t      r;
    logic [63:0]  num, den, idf, bb, l, d, tfn;
    logic [127:0] q, w;
    r.bad = 1'b0;
    r.weight = '0;
    if (avg_len == 0) begin
      r.bad = 1'b1;
      return r;
    end
    idf = 0;
    num = 2 * 64'(n_docs) + 2;
    den = 2 * 64'(df) + 1;
    if (df != 0 && num > den) begin
      q = (128'(num) << 32) / 128'(den);
      w = 128'(log2_frac24(q[63:0])) * 128'(LN2_Q32) + (128'(1) << 39);
      idf = 64'(w >> 40);
    end
    tfn = 0;
    if (tf != 0) begin
      bb = (b_norm > 256) ? 64'd256 : 64'(b_norm);
      l = (256 - bb) * 256 + ((bb * 64'(len)) << 16) / 64'(avg_len);
      d = (64'(tf) << 16) + ((64'(k1) * l) >> 8);
      tfn = ((64'(tf) * (64'(k1) + 256)) << 24) / d;
    end
    w = (128'(idf) * 128'(tfn) + 128'd32768) >> 16;
    r.weight = (w > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    return r;
  endfunction

  // One register write; the channel then goes quiet before the task returns.
  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TOTAL_DOCS: n_docs  = value[23:0];
      CFG_AVG_LEN:    avg_len = value;
      CFG_K1:         k1      = value[9:0];
      CFG_B:          b_norm  = value[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [23:0] n, logic [31:0] avg, logic [9:0] k,
                          logic [8:0] b);
    write_reg(CFG_TOTAL_DOCS, 32'(n));
    write_reg(CFG_AVG_LEN, avg);
    write_reg(CFG_K1, 32'(k));
    write_reg(CFG_B, 32'(b));
  endtask

  // Offer one request and hold it until accepted; the expectation is queued
  // at acceptance. The valid stays up for a following request unless the
  // sender idles first.
  task automatic send_posting(logic [15:0] tf, logic [23:0] len,
                              logic [23:0] df, bit known, weight_t typed);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {df, len, tf};
    do @(posedge clk); while (!in_tready);
    weight_queue.insert(weight_queue.size(), known ? typed : bm25_weight(tf, len, df));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (weight_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Receiver: random stalls and one long hold-off.
  always @(posedge clk) begin
    if (hold_recv) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) begin
        hold_recv <= 1'b0;
      end
    end else begin
      out_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    weight_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (weight_queue.size() == 0) begin
        $error("unexpected result weight_q16=%0h", out_tdata);
        fail_count++;
      end else begin
        want = weight_queue.pop_front();
        if (out_tdata !== want.weight) begin
          $error("weight_q16 expected %0h actual %0h", want.weight, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.bad) begin
          $error("bad_average expected %0b actual %0b", want.bad, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    posting_row_t rows[$];
    weight_t      typed;
    int           phase_idle[4];
    int           phase_stall[4];
    logic [15:0]  tf;
    logic [23:0]  len, df;
    logic [31:0]  avg;

    n_docs = 0; avg_len = 0; k1 = 10'd307; b_norm = 9'd192;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight after reset the average length is zero.
    send_posting(16'hFFFF, 24'hFFFFFF, 24'd1, 1'b1, '{32'd0, 1'b1});
    send_posting(16'd0, 24'd0, 24'd0, 1'b1, '{32'd0, 1'b1});
    drain();

    // Directed table.
    set_regs(24'd1000, 32'd100 << 8, 10'd307, 9'd192);
    write_reg(8'd9, 32'hFFFF_FFFF);  // unknown index, ignored
    rows = '{
      '{16'd1,    24'd100,     24'd0,        1'b1, 32'd0, 1'b0},  // zero df
      '{16'd0,    24'd100,     24'd10,       1'b1, 32'd0, 1'b0},  // zero tf
      '{16'd5,    24'd100,     24'd1001,     1'b1, 32'd0, 1'b0},  // df above N
      '{16'd5,    24'd100,     24'hFFFFFF,   1'b1, 32'd0, 1'b0},
      '{16'd1,    24'd100,     24'd1,        1'b0, 32'd0, 1'b0},
      '{16'hFFFF, 24'd0,       24'd1,        1'b0, 32'd0, 1'b0},
      '{16'hFFFF, 24'hFFFFFF,  24'd1,        1'b0, 32'd0, 1'b0},
      '{16'd3,    24'd50,      24'd500,      1'b0, 32'd0, 1'b0},
      '{16'd7,    24'd200,     24'd999,      1'b0, 32'd0, 1'b0},
      '{16'd2,    24'd1,       24'd1000,     1'b0, 32'd0, 1'b0}
    };
    foreach (rows[i]) begin
      typed = '{rows[i].weight, rows[i].bad};
      send_posting(rows[i].tf, rows[i].len, rows[i].df, rows[i].known, typed);
    end
    drain();

    // Extreme registers: b above one, largest N, k1 and average extremes.
    set_regs(24'hFFFFFF, 32'd1, 10'd1023, 9'd511);
    send_posting(16'hFFFF, 24'hFFFFFF, 24'd1, 1'b0, '0);
    send_posting(16'd1, 24'hFFFFFF, 24'd1, 1'b0, '0);
    send_posting(16'd1, 24'd0, 24'hFFFFFF, 1'b0, '0);
    drain();
    set_regs(24'hFFFFFF, 32'hFFFF_FFFF, 10'd0, 9'd0);
    send_posting(16'hFFFF, 24'hFFFFFF, 24'd1, 1'b0, '0);
    send_posting(16'd1, 24'd0, 24'd2, 1'b0, '0);
    drain();

    // Random phases with changing registers and idling.
    phase_idle  = '{0, 88, 0, 7};
    phase_stall = '{0, 0, 88, 7};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        avg = 32'd0;
      end else if (ph % 2) begin
        avg = $urandom;
      end else begin
        avg = 32'($urandom_range(1, 1 << 20));
      end
      set_regs(24'($urandom), avg, 10'($urandom), 9'($urandom_range(0, 300)));
      send_idle  = phase_idle[ph % 4];
      recv_stall = phase_stall[ph % 4];
      if (ph == 4) begin
        hold_cycles = 0;
        hold_recv = 1'b1;
      end
      for (int i = 0; i < 155; i++) begin
        tf  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        len = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000));
        df  = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, n_docs));
        send_posting(tf, len, df, 1'b0, '0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== bm25_term_weight_core.f =====
src/bm25_pkg.sv
src/bm25_div.sv
src/bm25_dly.sv
src/bm25_log.sv
src/bm25_term_weight_core.sv
tb/bm25_term_weight_core_tb.sv
